### rtl/chim_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chim_pkg
// Shared constants, types and the slot function of the chained hash index map.
// ----------------------------------------------------------------------------
package chim_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int TABLE_SLOTS = 256;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int KEY_W       = 64;
  localparam int MASK_W      = 4;
  localparam int OP_W        = 2;

  localparam logic [MASK_W-1:0] MASK_RESET = MASK_W'(8);
  localparam logic [MASK_W-1:0] MASK_MIN   = MASK_W'(1);
  localparam logic [MASK_W-1:0] MASK_MAX   = MASK_W'(8);

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } chim_link_t;

  typedef struct packed {
    logic              head_we;
    logic [SLOT_W-1:0] head_waddr;
    logic [IDX_W-1:0]  head_wdata;
    logic [SLOT_W-1:0] head_raddr;
    logic              ent_we;
    logic [IDX_W-1:0]  ent_waddr;
    logic [KEY_W-1:0]  key_wdata;
    chim_link_t        link_wdata;
    logic [IDX_W-1:0]  ent_raddr;
  } chim_mem_req_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [KEY_W-1:0] k,
                                                 input logic [MASK_W-1:0] mb);
    logic [MASK_W-1:0] mb_c;
    logic [8:0]        m;
    mb_c = mb;
    if (mb_c < MASK_MIN) mb_c = MASK_MIN;
    if (mb_c > MASK_MAX) mb_c = MASK_MAX;
    m = (9'd1 << mb_c) - 9'd1;
    return k[SLOT_W-1:0] & SLOT_W'(m);
  endfunction

endpackage
`default_nettype wire

### rtl/chim_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chim_in_if
// Request channel: op and key with valid/ready.
// ----------------------------------------------------------------------------
interface chim_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [chim_pkg::OP_W-1:0]            op;
  logic signed [chim_pkg::KEY_W-1:0]    key;

  modport source (output valid, op, key, input ready);
  modport sink   (input valid, op, key, output ready);
endinterface
`default_nettype wire

### rtl/chim_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chim_out_if
// Result channel: found, entry_index, full_res with valid/ready.
// ----------------------------------------------------------------------------
interface chim_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [chim_pkg::IDX_W-1:0]   entry_index;
  logic                         full_res;

  modport source (output valid, found, entry_index, full_res, input ready);
  modport sink   (input valid, found, entry_index, full_res, output ready);
endinterface
`default_nettype wire

### rtl/chained_hash_index_map_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_index_map_unit
// Separate-chaining hash table over 64-bit keys; one word in, one word out.
// ----------------------------------------------------------------------------
// Clear, unused op and full insert go straight to the result state; insert
// passes the insert state first; lookup reads the slot head, then compares
// chain entries one per cycle via the single comparator and entry read port.
// Throughput: one word at a time; in ready only while the sequencer is idle.
// Reset clears slot valid flops, entry count and sets mask_r to 8;
// memories are not swept.
module chained_hash_index_map_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  chim_in_if.sink                          in_word,
  chim_out_if.source                       out_word,
  input  wire logic                        cfg_we,
  input  wire logic [chim_pkg::MASK_W-1:0] cfg_wdata
);
  import chim_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_LK_HEAD = 3'd1;
  localparam logic [2:0] S_LK_CMP  = 3'd2;
  localparam logic [2:0] S_INS     = 3'd3;
  localparam logic [2:0] S_FIN     = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [MASK_W-1:0]      mask_r;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [TABLE_SLOTS-1:0] slot_vld_r, slot_vld_nxt;
  logic                   out_vld_r, out_vld_nxt;

  logic [KEY_W-1:0]       key_r, key_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [IDX_W-1:0]       cur_r, cur_nxt;
  logic                   res_found_r, res_found_nxt;
  logic [IDX_W-1:0]       res_idx_r, res_idx_nxt;
  logic                   res_full_r, res_full_nxt;
  logic                   o_found_r, o_found_nxt;
  logic [IDX_W-1:0]       o_idx_r, o_idx_nxt;
  logic                   o_full_r, o_full_nxt;

  chim_mem_req_t          req;
  logic [IDX_W-1:0]       head_rdata;
  logic [KEY_W-1:0]       key_rdata;
  chim_link_t             link_rdata;

  logic                   accept;
  logic                   out_free;
  logic [SLOT_W-1:0]      in_slot;
  logic [IDX_W-1:0]       pos;

  assign accept   = in_word.valid && in_word.ready;
  assign out_free = !out_vld_r || out_word.ready;
  assign in_slot  = slot_of($unsigned(in_word.key), mask_r);
  assign pos      = cnt_r[IDX_W-1:0];

  assign in_word.ready        = (state_r == S_IDLE);
  assign out_word.valid       = out_vld_r;
  assign out_word.found       = o_found_r;
  assign out_word.entry_index = o_idx_r;
  assign out_word.full_res    = o_full_r;

  chim_store u_store (
    .clk        (clk),
    .req        (req),
    .head_rdata (head_rdata),
    .key_rdata  (key_rdata),
    .link_rdata (link_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    slot_vld_nxt  = slot_vld_r;
    out_vld_nxt   = out_vld_r;
    key_nxt       = key_r;
    slot_nxt      = slot_r;
    cur_nxt       = cur_r;
    res_found_nxt = res_found_r;
    res_idx_nxt   = res_idx_r;
    res_full_nxt  = res_full_r;
    o_found_nxt   = o_found_r;
    o_idx_nxt     = o_idx_r;
    o_full_nxt    = o_full_r;

    req            = '0;
    req.head_raddr = slot_r;
    req.head_waddr = slot_r;
    req.head_wdata = pos;
    req.ent_waddr  = pos;
    req.key_wdata  = key_r;
    req.link_wdata = '{vld: slot_vld_r[slot_r], idx: head_rdata};
    req.ent_raddr  = link_rdata.idx;

    if (out_vld_r && out_word.ready) out_vld_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        req.head_raddr = in_slot;
        if (accept) begin
          key_nxt       = $unsigned(in_word.key);
          slot_nxt      = in_slot;
          res_found_nxt = 1'b0;
          res_idx_nxt   = '0;
          res_full_nxt  = 1'b0;
          state_nxt     = S_FIN;
          unique case (in_word.op)
            OP_CLEAR: begin
              slot_vld_nxt = '0;
              cnt_nxt      = '0;
            end
            OP_INSERT: begin
              if (cnt_r == CNT_W'(MAX_ENTRIES)) begin
                res_full_nxt = 1'b1;
              end else begin
                state_nxt = S_INS;
              end
            end
            OP_LOOKUP: begin
              state_nxt = S_LK_HEAD;
            end
            default: begin
            end
          endcase
        end
      end
      S_INS: begin
        req.head_we           = 1'b1;
        req.ent_we            = 1'b1;
        slot_vld_nxt[slot_r]  = 1'b1;
        cnt_nxt               = cnt_r + CNT_W'(1);
        res_found_nxt         = 1'b1;
        res_idx_nxt           = pos;
        state_nxt             = S_FIN;
      end
      S_LK_HEAD: begin
        req.ent_raddr = head_rdata;
        cur_nxt       = head_rdata;
        if (slot_vld_r[slot_r] && ({1'b0, head_rdata} < cnt_r)) begin
          state_nxt = S_LK_CMP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_LK_CMP: begin
        cur_nxt = link_rdata.idx;
        if (key_rdata == key_r) begin
          res_found_nxt = 1'b1;
          res_idx_nxt   = cur_r;
          state_nxt     = S_FIN;
        end else if (!(link_rdata.vld && ({1'b0, link_rdata.idx} < cnt_r))) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          o_found_nxt = res_found_r;
          o_idx_nxt   = res_idx_r;
          o_full_nxt  = res_full_r;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      mask_r     <= MASK_RESET;
      cnt_r      <= '0;
      slot_vld_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      slot_vld_r <= slot_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (cfg_we) mask_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    slot_r      <= slot_nxt;
    cur_r       <= cur_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    res_full_r  <= res_full_nxt;
    o_found_r   <= o_found_nxt;
    o_idx_r     <= o_idx_nxt;
    o_full_r    <= o_full_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above store size");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS |=> cnt_r == CNT_W'($past(cnt_r) + CNT_W'(1)))
    else $error("insert did not advance entry count");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LK_CMP |-> {1'b0, cur_r} < cnt_r)
    else $error("chain walk reached an unwritten entry");

  a_res_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(o_found_r && o_full_r))
    else $error("found and full both set");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_word.op == OP_LOOKUP |=> state_r == S_LK_HEAD && !in_word.ready)
    else $error("lookup not started after accept");

endmodule
`default_nettype wire

### rtl/chim_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chim_store
// Slot head memory plus entry key and link memories, registered reads.
// ----------------------------------------------------------------------------
module chim_store (
  input  wire logic                          clk,
  input  wire chim_pkg::chim_mem_req_t       req,
  output      logic [chim_pkg::IDX_W-1:0]    head_rdata,
  output      logic [chim_pkg::KEY_W-1:0]    key_rdata,
  output      chim_pkg::chim_link_t          link_rdata
);
  import chim_pkg::*;

  logic [IDX_W-1:0] head_mem [TABLE_SLOTS];
  logic [KEY_W-1:0] key_mem  [MAX_ENTRIES];
  chim_link_t       link_mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.head_we) begin
      head_mem[req.head_waddr] <= req.head_wdata;
    end
    head_rdata <= head_mem[req.head_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.ent_we) begin
      key_mem[req.ent_waddr]  <= req.key_wdata;
      link_mem[req.ent_waddr] <= req.link_wdata;
    end
    key_rdata  <= key_mem[req.ent_raddr];
    link_rdata <= link_mem[req.ent_raddr];
  end

endmodule
`default_nettype wire

### bench/chim_map_checker.sv
// ----------------------------------------------------------------------------
// chim_map_checker
// Watches the request, result and register ports of the chained hash index
// map. It keeps its own copy of the slot heads, entry keys and links, works
// out the answer to every accepted request word and compares each accepted
// result word with the oldest answer still owed.
// ----------------------------------------------------------------------------
module chim_map_checker
  import chim_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  chim_in_if              in_mon,
  chim_out_if             out_mon,
  input  logic            cfg_we,
  input  logic [MASK_W-1:0] cfg_wdata,
  output int              fail_count,
  output int              words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] entry_index;
    logic             full_res;
  } map_answer_t;

  logic [IDX_W-1:0]  head_at  [TABLE_SLOTS];
  logic              head_vld [TABLE_SLOTS];
  logic [KEY_W-1:0]  key_at   [MAX_ENTRIES];
  logic [IDX_W-1:0]  link_at  [MAX_ENTRIES];
  logic              link_vld [MAX_ENTRIES];
  int unsigned       used;
  logic [MASK_W-1:0] mask_reg;

  map_answer_t answers_due[$];
  int mismatches = 0;
  int waiting    = 0;

  assign fail_count    = mismatches;
  assign words_pending = waiting;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic int unsigned home_slot(input logic [KEY_W-1:0] key);
    int unsigned width;
    int unsigned low_mask;
    width = mask_reg;
    if (width < 1) width = 1;
    if (width > 8) width = 8;
    low_mask = (1 << width) - 1;
    return (key[31:0] & low_mask) % TABLE_SLOTS;
  endfunction

  function automatic map_answer_t table_answer(input logic [OP_W-1:0] op,
                                               input logic [KEY_W-1:0] key);
    map_answer_t ans;
    int unsigned s;
    int unsigned cur;
    int unsigned steps;
    logic        more;
    ans = '0;
    case (op)
      OP_CLEAR: begin
        head_vld = '{default: 1'b0};
        used = 0;
      end
      OP_INSERT: begin
        if (used >= MAX_ENTRIES) begin
          ans.full_res = 1'b1;
        end else begin
          s = home_slot(key);
          key_at[used]   = key;
          link_at[used]  = head_at[s];
          link_vld[used] = head_vld[s];
          head_at[s]     = IDX_W'(used);
          head_vld[s]    = 1'b1;
          ans.found       = 1'b1;
          ans.entry_index = IDX_W'(used);
          used++;
        end
      end
      OP_LOOKUP: begin
        s = home_slot(key);
        more = head_vld[s];
        cur = head_at[s];
        steps = 0;
        while (more && !ans.found && cur < used && steps < MAX_ENTRIES) begin
          if (key_at[cur] == key) begin
            ans.found       = 1'b1;
            ans.entry_index = IDX_W'(cur);
          end else begin
            more = link_vld[cur];
            cur  = link_at[cur];
            steps++;
          end
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin : watch
    map_answer_t got;
    map_answer_t want;
    if (!rst_n) begin
      head_vld = '{default: 1'b0};
      used = 0;
      mask_reg = MASK_RESET;
      answers_due.delete();
    end else begin
      if (cfg_we) mask_reg = cfg_wdata;
      if (in_mon.valid && in_mon.ready)
        answers_due.push_back(table_answer(in_mon.op, in_mon.key));
      if (out_mon.valid && out_mon.ready) begin
        got.found       = out_mon.found;
        got.entry_index = out_mon.entry_index;
        got.full_res    = out_mon.full_res;
        if (answers_due.size() == 0) begin
          report_mismatch("result word with no request outstanding");
        end else begin
          want = answers_due.pop_front();
          if (got.found !== want.found)
            report_mismatch($sformatf("found %b, expected %b", got.found, want.found));
          if (got.entry_index !== want.entry_index)
            report_mismatch($sformatf("entry_index %0d, expected %0d",
                                      got.entry_index, want.entry_index));
          if (got.full_res !== want.full_res)
            report_mismatch($sformatf("full_res %b, expected %b",
                                      got.full_res, want.full_res));
        end
      end
    end
    waiting <= answers_due.size();
  end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the chained hash index map: a directed run over key extremes,
// collisions, duplicates, unused op and clear, random words under a long
// result-side hold, a fill past the entry store limit, then random words
// over a small key pool under several mask settings and idling rates.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import chim_pkg::*;

  localparam logic [OP_W-1:0]  OP_UNUSED      = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX        = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [KEY_W-1:0] KEY_MIN        = 64'h8000_0000_0000_0000;
  localparam logic [KEY_W-1:0] KEY_ONES       = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int               RX_HOLD_CYCLES = 400;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [MASK_W-1:0] cfg_wdata;
  int                fail_count;
  int                words_pending;

  int send_idle_pct = 31;
  int recv_idle_pct = 86;
  int hold_requests = 0;

  logic [KEY_W-1:0] key_pool [16];

  chim_in_if  in_if ();
  chim_out_if out_if ();

  chained_hash_index_map_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_if),
    .out_word  (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  chim_map_checker map_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : rx_side
    int holds_done;
    holds_done = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_if.ready <= 1'b0;
      end else if (hold_requests != holds_done) begin
        holds_done++;
        out_if.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.op    <= op;
    in_if.key   <= key;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic write_mask(input logic [MASK_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // odd entries share the low byte of their neighbor to force collisions
  task automatic refill_pool();
    for (int i = 0; i < 16; i++) begin
      key_pool[i] = rand_key();
      if (i % 2 == 1) key_pool[i][7:0] = key_pool[i-1][7:0];
    end
  endtask

  task automatic random_words(input int count);
    int               r;
    logic [KEY_W-1:0] k;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      k = key_pool[$urandom_range(15)];
      if (r < 2)       send_word(OP_CLEAR, rand_key());
      else if (r < 4)  send_word(OP_UNUSED, k);
      else if (r < 44) send_word(OP_INSERT, k);
      else if (r < 84) send_word(OP_LOOKUP, k);
      else if (r < 94) send_word(OP_LOOKUP, rand_key());
      else             send_word(OP_INSERT, rand_key());
    end
  endtask

  initial begin : stimulus
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_if.valid  <= 1'b0;
    in_if.op     <= OP_CLEAR;
    in_if.key    <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset mask: 256 slots
    send_word(OP_LOOKUP, '0);
    send_word(OP_INSERT, KEY_MAX);
    send_word(OP_INSERT, KEY_MIN);
    send_word(OP_INSERT, KEY_ONES);
    send_word(OP_INSERT, '0);
    send_word(OP_INSERT, 64'd5);
    send_word(OP_INSERT, 64'd5);
    send_word(OP_INSERT, 64'd261);
    send_word(OP_LOOKUP, KEY_MAX);
    send_word(OP_LOOKUP, KEY_ONES);
    send_word(OP_LOOKUP, KEY_MIN);
    send_word(OP_LOOKUP, '0);
    send_word(OP_LOOKUP, 64'd5);
    send_word(OP_LOOKUP, 64'd261);
    send_word(OP_LOOKUP, 64'd517);
    send_word(OP_UNUSED, KEY_ONES);
    send_word(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
    send_word(OP_LOOKUP, 64'h5555_5555_5555_5555);
    send_word(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA);
    send_word(OP_CLEAR, KEY_ONES);
    send_word(OP_LOOKUP, 64'd5);
    send_word(OP_INSERT, 64'd5);
    send_word(OP_LOOKUP, 64'd5);

    // long result stall while requests keep coming
    refill_pool();
    hold_requests <= hold_requests + 1;
    random_words(20);
    drain();

    // two slots, fill past the store limit
    write_mask(MASK_MIN);
    send_word(OP_CLEAR, '0);
    for (int i = 0; i < MAX_ENTRIES + 2; i++) begin
      if (i % 3 == 0) send_word(OP_INSERT, rand_key());
      else            send_word(OP_INSERT, key_pool[$urandom_range(15)]);
    end
    for (int i = 0; i < 30; i++) send_word(OP_LOOKUP, key_pool[$urandom_range(15)]);
    drain();

    send_idle_pct = 86;
    recv_idle_pct = 31;
    write_mask(4'd4);
    refill_pool();
    random_words(120);
    drain();

    write_mask(4'd0);
    random_words(120);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_mask(4'd15);
    refill_pool();
    random_words(120);
    drain();

    write_mask(MASK_MAX);
    random_words(120);
    drain();

    repeat (20) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("[chained_hash_index_map_unit] OK");
    end else begin
      $display("[chained_hash_index_map_unit] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("[chained_hash_index_map_unit] ERROR");
    $finish;
  end

endmodule
